FILE: src/ptt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ptt_pkg;

  // Item operations.
  localparam logic [1:0] MODE_TICK = 2'd0;
  localparam logic [1:0] MODE_ADD  = 2'd1;
  localparam logic [1:0] MODE_DEL  = 2'd2;

  // Final result status codes.
  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_EXISTS    = 2'd1;
  localparam logic [1:0] STAT_NOT_FOUND = 2'd2;

  // Time constants in nanoseconds.
  localparam logic [30:0] ROUND_NS = 31'd250000000;
  localparam logic [30:0] NSEC_MAX = 31'd999999999;
  localparam logic [31:0] NS_PER_S = 32'd1000000000;

  typedef struct packed {
    logic [1:0]  mode;
    logic [3:0]  timer_id;
    logic [15:0] period_sec;
    logic [31:0] now_sec;
    logic [29:0] now_nsec;
  } in_t;

  typedef struct packed {
    logic        fired_valid;
    logic [3:0]  fired_id;
    logic [1:0]  status;
    logic        next_valid;
    logic [31:0] next_delay_sec;
    logic [29:0] next_delay_nsec;
    logic        last;
  } out_t;

  // One timer slot as held in the slot memory.
  typedef struct packed {
    logic [15:0] period;
    logic [31:0] dl_sec;
    logic [29:0] dl_nsec;
  } slot_entry_t;

  // Verdict of the scan logic on one slot.
  typedef struct packed {
    logic        expired;
    logic        keep;
    logic        take;
    logic [31:0] new_sec;
    logic [29:0] new_nsec;
  } eval_t;

endpackage

`default_nettype wire

FILE: src/ptt_mem.sv
`timescale 1ns / 1ps
`default_nettype none

module ptt_mem
  import ptt_pkg::*;
#(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  wire logic        clk,
  input  wire logic        wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire slot_entry_t wr_data,
  input  wire logic        rd_en,
  input  wire logic [AW-1:0] rd_addr,
  output slot_entry_t      rd_data
);

  slot_entry_t mem [DEPTH];

  // Single write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port; data holds while no read is issued.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

FILE: src/ptt_scan_eval.sv
`timescale 1ns / 1ps
`default_nettype none

module ptt_scan_eval
  import ptt_pkg::*;
(
  input  wire slot_entry_t entry,
  input  wire logic        active,
  input  wire logic        scan_fire,
  input  wire logic        del_here,
  input  wire logic [31:0] now_sec,
  input  wire logic [29:0] now_nsec,
  input  wire logic [29:0] lim_nsec,
  input  wire logic        found,
  input  wire logic [31:0] best_sec,
  input  wire logic [29:0] best_nsec,
  output eval_t            res
);

  logic        due;
  logic [31:0] dl_sec;
  logic [29:0] dl_nsec;

  // Expiry test against now plus the rounding window.
  assign due = (entry.dl_sec < now_sec) ||
               ((entry.dl_sec == now_sec) && (entry.dl_nsec <= lim_nsec));

  always_comb begin
    res.expired  = active && scan_fire && due;
    res.new_sec  = now_sec + 32'(entry.period);
    res.new_nsec = now_nsec;
    // Deadline after any re-arm takes part in the minimum search.
    dl_sec  = res.expired ? res.new_sec  : entry.dl_sec;
    dl_nsec = res.expired ? res.new_nsec : entry.dl_nsec;
    res.keep = active && !del_here;
    res.take = res.keep && (!found || (dl_sec < best_sec) ||
                            ((dl_sec == best_sec) && (dl_nsec < best_nsec)));
  end

endmodule

`default_nettype wire

FILE: src/ptt_delay.sv
`timescale 1ns / 1ps
`default_nettype none

module ptt_delay
  import ptt_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        load,
  input  wire logic [31:0] best_sec,
  input  wire logic [29:0] best_nsec,
  input  wire logic [31:0] now_sec,
  input  wire logic [29:0] now_nsec,
  output logic      [31:0] delay_sec,
  output logic      [29:0] delay_nsec
);

  logic [32:0] diff_sec;
  logic [30:0] diff_nsec;
  logic [32:0] adj_sec;
  logic [31:0] adj_nsec;

  // Raw signed differences, registered.
  always_ff @(posedge clk) begin
    if (load) begin
      diff_sec  <= {1'b0, best_sec} - {1'b0, now_sec};
      diff_nsec <= {1'b0, best_nsec} - {1'b0, now_nsec};
    end
  end

  // Borrow one second when the nanosecond part is negative, then clamp.
  always_comb begin
    if (diff_nsec[30]) begin
      adj_sec  = diff_sec - 33'd1;
      adj_nsec = {diff_nsec[30], diff_nsec} + NS_PER_S;
    end else begin
      adj_sec  = diff_sec;
      adj_nsec = {diff_nsec[30], diff_nsec};
    end
    delay_sec  = adj_sec[32] ? 32'd0 : adj_sec[31:0];
    delay_nsec = adj_nsec[29:0];
  end

endmodule

`default_nettype wire

FILE: src/periodic_timer_table.sv
`timescale 1ns / 1ps
`default_nettype none

// Table of TIMER_SLOTS periodic timers. Every item carries the current time;
// an add arms an idle slot, a tick or a valid delete scans all slots, sending
// one result per expired slot (in slot order) and re-arming it, and every item
// ends with a result that has last set, the status and the delay to the
// earliest remaining deadline. Slot data sits in a single-port-read memory and
// the scan reads one slot per cycle while no firing waits on out_ready. A new
// item is accepted only in IDLE, after the closing result of the previous one
// has gone into the output register. Adds, failed deletes and ticks all
// run the full scan, as the earliest deadline is searched in the same pass.
module periodic_timer_table
  import ptt_pkg::*;
#(
  parameter int TIMER_SLOTS = 16
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic      in_ready,
  input  wire in_t  in_data,
  output logic      out_valid,
  input  wire logic out_ready,
  output out_t      out_data
);

  localparam int SLOT_W = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(TIMER_SLOTS - 1);

  typedef enum logic [5:0] {
    IDLE  = 6'b000001,
    CHECK = 6'b000010,
    LOAD  = 6'b000100,
    SCAN  = 6'b001000,
    DIFF  = 6'b010000,
    FINAL = 6'b100000
  } state_t;

  state_t                  state;
  in_t                     item;
  logic [1:0]              status;
  logic                    scan_fire;
  logic                    del;
  logic [29:0]             lim_nsec;
  logic [SLOT_W-1:0]       idx;
  logic                    found;
  logic [31:0]             best_sec;
  logic [29:0]             best_nsec;
  logic [TIMER_SLOTS-1:0]  active;

  logic [SLOT_W-1:0] id_slot;
  logic              id_in_range;
  logic              id_active;
  logic [30:0]       lim_sum;
  logic              out_free;
  logic              stall;
  logic              add_ok;

  slot_entry_t       rd_data;
  slot_entry_t       wr_data;
  logic              wr_en;
  logic [SLOT_W-1:0] wr_addr;
  logic              rd_en;
  logic [SLOT_W-1:0] rd_addr;
  eval_t             ev;
  logic [31:0]       delay_sec;
  logic [29:0]       delay_nsec;

  assign in_ready    = (state == IDLE);
  assign out_free    = !out_valid || out_ready;
  assign id_slot     = SLOT_W'(item.timer_id);
  assign id_in_range = (32'(item.timer_id) < TIMER_SLOTS);
  assign id_active   = id_in_range && active[id_slot];
  assign add_ok      = (item.mode == MODE_ADD) && id_in_range && !id_active;
  assign lim_sum     = {1'b0, item.now_nsec} + ROUND_NS;
  assign stall       = (state == SCAN) && ev.expired && !out_free;

  ptt_mem #(
    .DEPTH (TIMER_SLOTS),
    .AW    (SLOT_W)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  ptt_scan_eval u_eval (
    .entry     (rd_data),
    .active    (active[idx]),
    .scan_fire (scan_fire),
    .del_here  (del && (idx == id_slot)),
    .now_sec   (item.now_sec),
    .now_nsec  (item.now_nsec),
    .lim_nsec  (lim_nsec),
    .found     (found),
    .best_sec  (best_sec),
    .best_nsec (best_nsec),
    .res       (ev)
  );

  ptt_delay u_delay (
    .clk        (clk),
    .load       (state == DIFF),
    .best_sec   (best_sec),
    .best_nsec  (best_nsec),
    .now_sec    (item.now_sec),
    .now_nsec   (item.now_nsec),
    .delay_sec  (delay_sec),
    .delay_nsec (delay_nsec)
  );

  // Memory port control: arm on a good add, read slots for the scan, re-arm on expiry.
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = idx;
    wr_data = rd_data;
    rd_en   = 1'b0;
    rd_addr = idx + SLOT_W'(1);
    case (state)
      CHECK: begin
        wr_en           = add_ok;
        wr_addr         = id_slot;
        wr_data.period  = item.period_sec;
        wr_data.dl_sec  = item.now_sec + 32'(item.period_sec);
        wr_data.dl_nsec = item.now_nsec;
      end
      LOAD: begin
        rd_en   = 1'b1;
        rd_addr = '0;
      end
      SCAN: begin
        wr_en           = ev.expired && !stall;
        wr_data.dl_sec  = ev.new_sec;
        wr_data.dl_nsec = ev.new_nsec;
        rd_en           = !stall && (idx != LAST_SLOT);
      end
      default: begin
      end
    endcase
  end

  // Sequencer, slot flags and minimum search.
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= IDLE;
      active <= '0;
    end else begin
      case (state)
        IDLE: begin
          if (in_valid) begin
            item  <= in_data;
            state <= CHECK;
          end
        end
        CHECK: begin
          lim_nsec  <= (lim_sum > NSEC_MAX) ? NSEC_MAX[29:0] : lim_sum[29:0];
          found     <= 1'b0;
          scan_fire <= 1'b0;
          del       <= 1'b0;
          status    <= STAT_OK;
          case (item.mode)
            MODE_ADD: begin
              if (!id_in_range) begin
                status <= STAT_NOT_FOUND;
              end else if (id_active) begin
                status <= STAT_EXISTS;
              end else begin
                active[id_slot] <= 1'b1;
              end
            end
            MODE_DEL: begin
              if (!id_active) begin
                status <= STAT_NOT_FOUND;
              end else begin
                scan_fire <= 1'b1;
                del       <= 1'b1;
              end
            end
            default: begin
              scan_fire <= 1'b1;
            end
          endcase
          state <= LOAD;
        end
        LOAD: begin
          idx   <= '0;
          state <= SCAN;
        end
        SCAN: begin
          if (!stall) begin
            if (del && (idx == id_slot)) begin
              active[idx] <= 1'b0;
            end
            if (ev.take) begin
              found     <= 1'b1;
              best_sec  <= ev.expired ? ev.new_sec  : rd_data.dl_sec;
              best_nsec <= ev.expired ? ev.new_nsec : rd_data.dl_nsec;
            end
            if (idx == LAST_SLOT) begin
              state <= DIFF;
            end else begin
              idx <= idx + SLOT_W'(1);
            end
          end
        end
        DIFF: begin
          state <= FINAL;
        end
        FINAL: begin
          if (out_free) begin
            state <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == SCAN) && ev.expired && out_free) begin
      out_valid <= 1'b1;
    end else if ((state == FINAL) && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == SCAN) && ev.expired && out_free) begin
      out_data.fired_valid     <= 1'b1;
      out_data.fired_id        <= 4'(idx);
      out_data.status          <= STAT_OK;
      out_data.next_valid      <= 1'b0;
      out_data.next_delay_sec  <= '0;
      out_data.next_delay_nsec <= '0;
      out_data.last            <= 1'b0;
    end else if ((state == FINAL) && out_free) begin
      out_data.fired_valid     <= 1'b0;
      out_data.fired_id        <= '0;
      out_data.status          <= status;
      out_data.next_valid      <= found;
      out_data.next_delay_sec  <= found ? delay_sec  : 32'd0;
      out_data.next_delay_nsec <= found ? delay_nsec : 30'd0;
      out_data.last            <= 1'b1;
    end
  end

  // A firing that waits on the output holds the scan on the same slot.
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    stall |=> (state == SCAN) && $stable(idx))
    else $error("scan advanced while a firing was stalled");

  // A successful add leaves its slot armed.
  a_add_arms: assert property (@(posedge clk) disable iff (rst)
    (state == CHECK) && add_ok |=> active[$past(id_slot)])
    else $error("add did not arm its slot");

  // The closing result never reports a firing.
  a_last_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.last |-> !out_data.fired_valid && (out_data.fired_id == 4'd0))
    else $error("final result carries a firing");

  // No item is taken while a result from the scan is still being produced.
  a_idle_only: assert property (@(posedge clk) disable iff (rst)
    (state == SCAN) || (state == FINAL) |-> !in_ready)
    else $error("input ready during scan");

endmodule

`default_nettype wire
